@@ hdl/fpe_pkg.sv @@
// Package for the frustum plane extractor.
// Shared types, constants and plane tables; no dependencies.
`timescale 1ns / 1ps

package fpe_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PLANES    = 6;

	// How a plane combines row 3 with its selected row.
	localparam logic [1:0] PS_ADD  = 2'd0;
	localparam logic [1:0] PS_SUB  = 2'd1;
	localparam logic [1:0] PS_PASS = 2'd2;

	localparam logic [2:0] PLANE_FAR = 3'd5;

	typedef struct packed {
		logic       rd;       // read and combine the matrix rows
		logic [3:0] rd_cnt;
		logic       shift;    // halve all magnitudes
		logic       sq;       // accumulate one square
		logic       rt_init;
		logic       rt_step;
		logic       dv_init;
		logic       dv_step;
		logic       dv_fin;
		logic       emit;
		logic [2:0] plane;
		logic [1:0] k;
	} cmd_t;

	typedef struct packed {
		logic big;       // some normal component still needs a shift
		logic zero;      // normal is all zero
		logic out_free;  // output register can take a result
	} status_t;

	function automatic logic [1:0] plane_row(input logic [2:0] p);
		case (p)
			3'd0, 3'd1: plane_row = 2'd0;
			3'd2, 3'd3: plane_row = 2'd1;
			default:    plane_row = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] plane_sign(input logic [2:0] p);
		case (p)
			3'd0, 3'd2: plane_sign = PS_ADD;
			3'd4:       plane_sign = PS_PASS;
			default:    plane_sign = PS_SUB;
		endcase
	endfunction

endpackage

@@ hdl/fpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/fpe_ctrl.sv @@
// Sequencer of the frustum plane extractor.
// Depends on fpe_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps

module fpe_ctrl import fpe_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int PRE = (DATA_WIDTH > 62) ? DATA_WIDTH - 62 : 0;
	localparam int NW  = DATA_WIDTH - PRE + 1 + FRAC_BITS;
	localparam int CW  = $clog2(NW + 34);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_SQ    = 3'd3;
	localparam logic [2:0] ST_SQRT  = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]    plane_q;
	logic [1:0]    k_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.plane   = plane_q;
		cmd.k       = k_q;
		cmd.rd_cnt  = cnt_q[3:0];
		case (state_q)
			ST_READ:  cmd.rd = 1'b1;
			ST_SHIFT: cmd.shift = status.big;
			ST_SQ: begin
				cmd.sq = 1'b1;
				cmd.k  = cnt_q[1:0];
			end
			ST_SQRT: begin
				cmd.rt_init = (cnt_q == '0);
				cmd.rt_step = (cnt_q != '0);
			end
			ST_DIV: begin
				cmd.dv_init = (cnt_q == '0);
				cmd.dv_fin  = (cnt_q == CW'(NW + 1));
				cmd.dv_step = !cmd.dv_init && !cmd.dv_fin;
			end
			ST_EMIT:  cmd.emit = status.out_free;
			default:  cmd.rd = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			plane_q <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_last) begin
						state_q <= ST_READ;
						cnt_q   <= '0;
						plane_q <= '0;
					end
				end
				ST_READ: begin
					if (cnt_q == CW'(8)) begin
						state_q <= ST_SHIFT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SHIFT: begin
					if (!status.big) begin
						state_q <= status.zero ? ST_EMIT : ST_SQ;
						cnt_q   <= '0;
					end
				end
				ST_SQ: begin
					if (cnt_q == CW'(2)) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CW'(32)) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						k_q     <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == CW'(NW + 1)) begin
						cnt_q <= '0;
						if (k_q == 2'd3) begin
							state_q <= ST_EMIT;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						cnt_q <= '0;
						if (plane_q == PLANE_FAR) begin
							state_q <= ST_IDLE;
						end else begin
							plane_q <= plane_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/fpe_datapath.sv @@
// Datapath of the frustum plane extractor: matrix store, row combine,
// range shift, sum of squares, bit-serial square root and divider, output register.
// Depends on fpe_pkg and fpe_ram.
`timescale 1ns / 1ps

module fpe_datapath import fpe_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  wr_en,
	input  logic [DATA_WIDTH-1:0] wr_value,
	input  logic [1:0]            wr_col,
	input  logic [1:0]            wr_row,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            out_plane,
	output logic [DATA_WIDTH-1:0] out_a,
	output logic [DATA_WIDTH-1:0] out_b,
	output logic [DATA_WIDTH-1:0] out_c,
	output logic [DATA_WIDTH-1:0] out_d,
	output logic                  out_zero,
	output logic                  out_last
);

	localparam int DW  = DATA_WIDTH;
	localparam int PRE = (DW > 62) ? DW - 62 : 0;
	localparam int EW  = DW - PRE;
	localparam int SW  = EW + 1;
	localparam int NW  = SW + FRAC_BITS;

	// Matrix store; entries never written read as zero.
	logic [15:0]   vld_q;
	logic          vld_s1;
	logic [3:0]    raddr;
	logic [DW-1:0] rdata;

	assign raddr = {cmd.rd_cnt[2:1], cmd.rd_cnt[0] ? plane_row(cmd.plane) : 2'd3};

	fpe_ram #(.WIDTH(DW), .DEPTH(16)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr ({wr_col, wr_row}),
		.wdata (wr_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[{wr_col, wr_row}] <= 1'b1;
			end
			vld_s1 <= vld_q[raddr];
		end
	end

	// Element with the wide-word pre-shift applied to its magnitude.
	logic [DW-1:0]        raw;
	logic [DW-1:0]        raw_mag;
	logic [DW-1:0]        e_mag;
	logic signed [SW-1:0] e_val;
	logic signed [SW-1:0] base_q;
	logic signed [SW-1:0] v_sum;
	logic [SW-1:0]        v_mag;
	logic [3:0]           cap_idx;

	assign raw     = vld_s1 ? rdata : '0;
	assign raw_mag = raw[DW-1] ? DW'(0) - raw : raw;
	assign e_mag   = raw_mag >> PRE;
	assign e_val   = raw[DW-1] ? -$signed(SW'(e_mag)) : $signed(SW'(e_mag));
	assign cap_idx = cmd.rd_cnt - 4'd1;

	always_comb begin
		case (plane_sign(cmd.plane))
			PS_ADD:  v_sum = base_q + e_val;
			PS_SUB:  v_sum = base_q - e_val;
			default: v_sum = e_val;
		endcase
	end

	assign v_mag = v_sum[SW-1] ? SW'(0) - SW'(v_sum) : SW'(v_sum);

	logic [SW-1:0] mag_q [4];
	logic [3:0]    neg_q;
	logic [2:0]    big_k;
	logic [2:0]    nz_k;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			big_k[i] = (64'(mag_q[i]) >= 64'h8000_0000);
			nz_k[i]  = (mag_q[i] != '0);
		end
	end

	assign status.big  = |big_k;
	assign status.zero = ~|nz_k;

	// Sum of squares, square root and division registers.
	logic [63:0] s2_q;
	logic [63:0] sq_ext;
	logic [30:0] sq_op;
	logic [61:0] sq_prod;
	logic [63:0] rv_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] res_bit;
	logic [31:0] root;
	logic [NW-1:0] n_q;
	logic [31:0]   rem_q;
	logic [32:0]   dv_t;
	logic          dv_ge;
	logic [DW-1:0] coef_q [4];

	assign sq_ext  = 64'(mag_q[cmd.k]);
	assign sq_op   = sq_ext[30:0];
	assign sq_prod = sq_op * sq_op;
	assign res_bit = res_q + bit_q;
	assign root    = res_q[31:0];
	assign dv_t    = {rem_q, n_q[NW-1]};
	assign dv_ge   = (dv_t >= {1'b0, root});

	function automatic logic [DW-1:0] sat_f(input logic [NW-1:0] m, input logic neg);
		logic [NW-1:0] lim;
		lim = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};
		if (m > lim) begin
			sat_f = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			sat_f = neg ? DW'(0) - m[DW-1:0] : m[DW-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.rd && cmd.rd_cnt == 4'd0) begin
			s2_q <= '0;
		end
		if (cmd.rd && cmd.rd_cnt != 4'd0) begin
			if (!cap_idx[0]) begin
				base_q <= e_val;
			end else begin
				mag_q[cap_idx[2:1]] <= v_mag;
				neg_q[cap_idx[2:1]] <= v_sum[SW-1];
			end
		end
		if (cmd.shift) begin
			for (int i = 0; i < 4; i++) begin
				mag_q[i] <= mag_q[i] >> 1;
			end
		end
		if (cmd.sq) begin
			s2_q <= s2_q + 64'(sq_prod);
		end
		if (cmd.rt_init) begin
			rv_q  <= s2_q;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end
		if (cmd.rt_step) begin
			if (rv_q >= res_bit) begin
				rv_q  <= rv_q - res_bit;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.dv_init) begin
			// Dividend carries the rounding term half the divisor.
			n_q   <= (NW'(mag_q[cmd.k]) << FRAC_BITS) + NW'(root >> 1);
			rem_q <= '0;
		end
		if (cmd.dv_step) begin
			rem_q <= dv_ge ? 32'(dv_t - {1'b0, root}) : dv_t[31:0];
			n_q   <= {n_q[NW-2:0], dv_ge};
		end
		if (cmd.dv_fin) begin
			coef_q[cmd.k] <= sat_f(n_q, neg_q[cmd.k]);
		end
		if (cmd.emit) begin
			out_plane <= cmd.plane;
			out_zero  <= status.zero;
			out_last  <= (cmd.plane == PLANE_FAR);
			out_a     <= status.zero ? '0 : coef_q[0];
			out_b     <= status.zero ? '0 : coef_q[1];
			out_c     <= status.zero ? '0 : coef_q[2];
			out_d     <= status.zero ? sat_f(NW'(mag_q[3]) << PRE, neg_q[3]) : coef_q[3];
		end
	end

	assign status.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

@@ hdl/frustum_plane_extractor.sv @@
// Top level of the frustum plane extractor.
// Depends on fpe_pkg, fpe_ctrl, fpe_datapath and fpe_ram.
//
// The slave channel takes matrix elements, one per transfer, addressed by
// column and row; one element is taken per cycle while the block is idle.
// The transfer with tlast high stores its element and starts the six planes
// (left, right, bottom, top, near, far), which leave on the master channel
// one per transfer, tlast marking the far plane.
// Per plane the sequencer reads and combines rows, tests the range of the
// normal and halves an oversized normal until it fits, forms the squares,
// runs the bit-serial square root and then the bit-serial divider once per
// coefficient, and then emits the plane.
// A zero normal skips the squares, root and divider. No element is taken while planes
// are computed. A stalled receiver holds the result in the output register
// and the sequencer waits. Reset clears the matrix to zero and idles the block.
`timescale 1ns / 1ps

module frustum_plane_extractor import fpe_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// element_value, column_index, row_index, zero padding
	input  logic [((DATA_WIDTH+4+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// coef_a, coef_b, coef_c, coef_d, zero padding
	output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// plane_index, zero_normal, zero padding
	output logic [7:0] m_tuser,
	output logic m_tlast
);

	localparam int DW  = DATA_WIDTH;
	localparam int ODW = ((4*DW+7)/8)*8;

	cmd_t          cmd;
	status_t       status;
	logic          accept;
	logic [2:0]    plane;
	logic          zero;
	logic [DW-1:0] ca, cb, cc, cd;

	assign accept = s_tvalid && s_tready;

	fpe_ctrl #(.DATA_WIDTH(DW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fpe_datapath #(.DATA_WIDTH(DW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.wr_en     (accept),
		.wr_value  (s_tdata[DW-1:0]),
		.wr_col    (s_tdata[DW+1:DW]),
		.wr_row    (s_tdata[DW+3:DW+2]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_plane (plane),
		.out_a     (ca),
		.out_b     (cb),
		.out_c     (cc),
		.out_d     (cd),
		.out_zero  (zero),
		.out_last  (m_tlast)
	);

	assign m_tdata = ODW'({cd, cc, cb, ca});
	assign m_tuser = {4'd0, zero, plane};

endmodule
